@@ rtl/pse_pkg.sv @@
// Shared types, constants and helpers for the postfix stack evaluator.
// No dependencies; every other rtl file imports this package.
package pse_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int SP_W        = $clog2(STACK_DEPTH + 1);
    localparam int DATA_W      = 32;
    localparam int CNT_W       = $clog2(DATA_W);

    // sticky status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_UNDER = 2'd1;
    localparam logic [1:0] ST_OVER  = 2'd2;
    localparam logic [1:0] ST_DIVZ  = 2'd3;

    // ASCII codes
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_CARET = 8'h5E;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV,
        OP_ZERO
    } alu_op_t;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_mark;
    } char_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic [1:0]               status;
    } result_t;

    typedef struct packed {
        logic              start;
        alu_op_t           op;
        logic [DATA_W-1:0] lhs;
        logic [DATA_W-1:0] rhs;
    } alu_req_t;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] result;
    } alu_rsp_t;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [DATA_W-1:0] wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } stack_req_t;

    function automatic logic char_is_num(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic alu_op_t decode_op(input logic [7:0] c);
        alu_op_t op;
        unique case (c)
            CH_PLUS:  op = OP_ADD;
            CH_MINUS: op = OP_SUB;
            CH_STAR:  op = OP_MUL;
            CH_SLASH: op = OP_DIV;
            CH_CARET: op = OP_ZERO;
            default:  op = OP_NONE;
        endcase
        return op;
    endfunction

    // first error of an expression wins
    function automatic logic [1:0] flag_error(input logic [1:0] cur, input logic [1:0] code);
        return (cur == ST_OK) ? code : cur;
    endfunction

endpackage

@@ rtl/postfix_stack_evaluator.sv @@
// Postfix stack evaluator, top level: sequencer, number builder and status.
// Depends on pse_pkg, pse_stack and pse_alu.
//
// Takes a postfix expression one ASCII character per transfer; end_mark tags
// the last character. Digit runs build a 32-bit number (wrapping), pushed when
// the run ends. + - * / ^ pop two values (left operand below the top) and push
// the 32-bit wrapped result; / truncates toward zero, ^ gives 0, anything
// else separates tokens. On the last character, after it is processed, any
// pending number is pushed and one result transfer carries the top of stack
// and a sticky status (first error wins: 1 underflow, 2 overflow, 3 divide
// by zero); the evaluator then clears for the next expression. An empty
// stack at the end gives value 0 with underflow. An operator takes two reads of
// the single-read-port stack memory, then one pass through the shared ALU;
// / waits on the 32-step restoring divider in the ALU. The last character
// also needs the top-of-stack read and the output load. char_stall is high
// while a character is being worked on. One result can sit in the output
// register while the next expression streams in.
module postfix_stack_evaluator (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              char_valid,
    output logic              char_stall,
    input  pse_pkg::char_t    char_data,
    output logic              result_valid,
    input  logic              result_stall,
    output pse_pkg::result_t  result_data
);
    import pse_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_NUM,
        S_RD1,
        S_RD2,
        S_EXEC,
        S_ALU,
        S_TOP,
        S_TOPW,
        S_EMIT
    } seq_state_t;

    seq_state_t        state_reg, state_next;
    logic [SP_W-1:0]   sp_reg, sp_next;
    logic [DATA_W-1:0] acc_reg, acc_next;
    logic              innum_reg, innum_next;
    logic [1:0]        err_reg, err_next;
    logic [7:0]        ch_reg, ch_next;
    logic              last_reg, last_next;
    logic [DATA_W-1:0] rhs_reg, rhs_next;
    logic [DATA_W-1:0] val_reg, val_next;
    logic              result_valid_reg, result_valid_next;
    result_t           result_reg, result_next;

    stack_req_t        stk_req;
    logic [DATA_W-1:0] stk_rd_data;
    alu_req_t          alu_req;
    alu_rsp_t          alu_rsp;

    logic [SP_W-1:0]   sp_m1;
    logic [SP_W-1:0]   sp_m2;
    alu_op_t           ch_op;
    logic [3:0]        digit;
    logic              emit_go;

    assign sp_m1   = sp_reg - 1'b1;
    assign sp_m2   = sp_reg - 2'd2;
    assign ch_op   = decode_op(ch_reg);
    assign digit   = 4'(char_data.char_code - CH_ZERO);
    assign emit_go = !result_valid_reg || !result_stall;

    pse_stack u_stack (
        .clk     (clk),
        .req     (stk_req),
        .rd_data (stk_rd_data)
    );

    pse_alu u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (alu_req),
        .rsp   (alu_rsp)
    );

    always_comb
    begin
        state_next        = state_reg;
        sp_next           = sp_reg;
        acc_next          = acc_reg;
        innum_next        = innum_reg;
        err_next          = err_reg;
        ch_next           = ch_reg;
        last_next         = last_reg;
        rhs_next          = rhs_reg;
        val_next          = val_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg && result_stall;

        stk_req.wr_en   = 1'b0;
        stk_req.wr_addr = sp_reg[ADDR_W-1:0];
        stk_req.wr_data = acc_reg;
        stk_req.rd_en   = 1'b0;
        stk_req.rd_addr = sp_m1[ADDR_W-1:0];

        alu_req.start = 1'b0;
        alu_req.op    = ch_op;
        alu_req.lhs   = stk_rd_data;
        alu_req.rhs   = rhs_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (char_valid)
                begin
                    ch_next   = char_data.char_code;
                    last_next = char_data.end_mark;
                    if (char_is_num(char_data.char_code))
                    begin
                        // acc * 10 + digit, wrapping
                        acc_next   = (acc_reg << 3) + (acc_reg << 1) + DATA_W'(digit);
                        innum_next = 1'b1;
                        state_next = char_data.end_mark ? S_NUM : S_IDLE;
                    end
                    else
                    begin
                        state_next = S_NUM;
                    end
                end
            end
            S_NUM:
            begin
                // close an open digit run
                if (innum_reg)
                begin
                    if (sp_reg < SP_W'(STACK_DEPTH))
                    begin
                        stk_req.wr_en = 1'b1;
                        sp_next       = sp_reg + 1'b1;
                    end
                    else
                    begin
                        err_next = flag_error(err_reg, ST_OVER);
                    end
                    acc_next   = '0;
                    innum_next = 1'b0;
                end
                if (ch_op != OP_NONE)
                begin
                    state_next = S_RD1;
                end
                else
                begin
                    state_next = last_reg ? S_TOP : S_IDLE;
                end
            end
            S_RD1:
            begin
                if (sp_reg < SP_W'(2))
                begin
                    err_next   = flag_error(err_reg, ST_UNDER);
                    state_next = last_reg ? S_TOP : S_IDLE;
                end
                else
                begin
                    stk_req.rd_en = 1'b1;
                    state_next    = S_RD2;
                end
            end
            S_RD2:
            begin
                rhs_next        = stk_rd_data;
                stk_req.rd_en   = 1'b1;
                stk_req.rd_addr = sp_m2[ADDR_W-1:0];
                state_next      = S_EXEC;
            end
            S_EXEC:
            begin
                alu_req.start = 1'b1;
                if (ch_op == OP_DIV && rhs_reg == '0)
                begin
                    err_next = flag_error(err_reg, ST_DIVZ);
                end
                state_next = S_ALU;
            end
            S_ALU:
            begin
                if (alu_rsp.done)
                begin
                    // two popped, one pushed
                    stk_req.wr_en   = 1'b1;
                    stk_req.wr_addr = sp_m2[ADDR_W-1:0];
                    stk_req.wr_data = alu_rsp.result;
                    sp_next         = sp_m1;
                    state_next      = last_reg ? S_TOP : S_IDLE;
                end
            end
            S_TOP:
            begin
                if (sp_reg == '0)
                begin
                    err_next   = flag_error(err_reg, ST_UNDER);
                    val_next   = '0;
                    state_next = S_EMIT;
                end
                else
                begin
                    stk_req.rd_en = 1'b1;
                    state_next    = S_TOPW;
                end
            end
            S_TOPW:
            begin
                val_next   = stk_rd_data;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (emit_go)
                begin
                    result_next.value  = val_reg;
                    result_next.status = err_reg;
                    result_valid_next  = 1'b1;
                    sp_next            = '0;
                    acc_next           = '0;
                    innum_next         = 1'b0;
                    err_next           = ST_OK;
                    state_next         = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            sp_reg           <= '0;
            acc_reg          <= '0;
            innum_reg        <= 1'b0;
            err_reg          <= ST_OK;
            last_reg         <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            sp_reg           <= sp_next;
            acc_reg          <= acc_next;
            innum_reg        <= innum_next;
            err_reg          <= err_next;
            last_reg         <= last_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ch_reg     <= ch_next;
        rhs_reg    <= rhs_next;
        val_reg    <= val_next;
        result_reg <= result_next;
    end

    assign char_stall   = (state_reg != S_IDLE);
    assign result_valid = result_valid_reg;
    assign result_data  = result_reg;

    // stack pointer stays within the stack
    a_sp_range: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= SP_W'(STACK_DEPTH))
        else $error("stack pointer beyond stack depth");

    // a new result only comes out of the emit step
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(state_reg == S_EMIT))
        else $error("result raised outside emit");

    // ALU completion only while the sequencer waits for it
    a_alu_done: assert property (@(posedge clk) disable iff (!rst_n)
        alu_rsp.done |-> (state_reg == S_ALU))
        else $error("unexpected ALU completion");

    // an emitted expression leaves a cleared evaluator behind
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && emit_go) |=>
            (sp_reg == '0 && err_reg == ST_OK && !innum_reg && state_reg == S_IDLE))
        else $error("state not cleared after result");

endmodule

@@ rtl/pse_stack.sv @@
// Value stack storage: one write port, one read port, registered read data.
// Depends on pse_pkg.
module pse_stack (
    input  logic                        clk,
    input  pse_pkg::stack_req_t         req,
    output logic [pse_pkg::DATA_W-1:0]  rd_data
);
    import pse_pkg::*;

    logic [DATA_W-1:0] mem [STACK_DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/pse_alu.sv @@
// Shared arithmetic unit: add, subtract and low-word multiply with a registered result,
// signed truncating divide by restoring iteration, one quotient bit per cycle.
// Depends on pse_pkg.
module pse_alu (
    input  logic               clk,
    input  logic               rst_n,
    input  pse_pkg::alu_req_t  req,
    output pse_pkg::alu_rsp_t  rsp
);
    import pse_pkg::*;

    typedef enum logic [1:0] {
        A_IDLE,
        A_DIV,
        A_FIX
    } alu_state_t;

    alu_state_t        state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DATA_W-1:0] quo_reg, quo_next;
    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [DATA_W-1:0] den_reg, den_next;
    logic              neg_reg, neg_next;
    logic              done_reg, done_next;
    logic [DATA_W-1:0] res_reg, res_next;

    logic [DATA_W:0]   trial;
    logic [DATA_W-1:0] mul_lo;
    logic [DATA_W-1:0] abs_lhs;
    logic [DATA_W-1:0] abs_rhs;

    assign trial   = {rem_reg, quo_reg[DATA_W-1]} - {1'b0, den_reg};
    assign mul_lo  = req.lhs * req.rhs;
    assign abs_lhs = req.lhs[DATA_W-1] ? (~req.lhs + 1'b1) : req.lhs;
    assign abs_rhs = req.rhs[DATA_W-1] ? (~req.rhs + 1'b1) : req.rhs;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        den_next   = den_reg;
        neg_next   = neg_reg;
        done_next  = 1'b0;
        res_next   = res_reg;
        unique case (state_reg)
            A_IDLE:
            begin
                if (req.start)
                begin
                    case (req.op)
                        OP_ADD:
                        begin
                            res_next  = req.lhs + req.rhs;
                            done_next = 1'b1;
                        end
                        OP_SUB:
                        begin
                            res_next  = req.lhs - req.rhs;
                            done_next = 1'b1;
                        end
                        OP_MUL:
                        begin
                            res_next  = mul_lo;
                            done_next = 1'b1;
                        end
                        OP_DIV:
                        begin
                            if (req.rhs == '0)
                            begin
                                res_next  = '0;
                                done_next = 1'b1;
                            end
                            else
                            begin
                                quo_next   = abs_lhs;
                                den_next   = abs_rhs;
                                rem_next   = '0;
                                neg_next   = req.lhs[DATA_W-1] ^ req.rhs[DATA_W-1];
                                cnt_next   = '0;
                                state_next = A_DIV;
                            end
                        end
                        default:
                        begin
                            res_next  = '0;
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            A_DIV:
            begin
                if (!trial[DATA_W])
                begin
                    rem_next = trial[DATA_W-1:0];
                    quo_next = {quo_reg[DATA_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = {rem_reg[DATA_W-2:0], quo_reg[DATA_W-1]};
                    quo_next = {quo_reg[DATA_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DATA_W - 1))
                begin
                    state_next = A_FIX;
                end
            end
            A_FIX:
            begin
                // most negative / -1 wraps back to most negative here
                res_next   = neg_reg ? (~quo_reg + 1'b1) : quo_reg;
                done_next  = 1'b1;
                state_next = A_IDLE;
            end
            default:
            begin
                state_next = A_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= A_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
        res_reg <= res_next;
    end

    assign rsp.done   = done_reg;
    assign rsp.result = res_reg;

endmodule

@@ sim/tb_top.sv @@
// Self-checking testbench for postfix_stack_evaluator: directed and random expressions,
// random idling on both channels, per-field result checks in order.
// Depends on pse_pkg and the rtl of postfix_stack_evaluator.
module tb_top;
    import pse_pkg::*;

    // ------------------------------------------------------------------
    // Clock, reset and block connections
    // ------------------------------------------------------------------
    logic    clk;
    logic    rst_n;
    logic    char_valid   = 1'b0;
    logic    char_stall;
    char_t   char_data    = '0;
    logic    result_valid;
    logic    result_stall = 1'b0;
    result_t result_data;

    postfix_stack_evaluator u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .char_valid   (char_valid),
        .char_stall   (char_stall),
        .char_data    (char_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // single reset at start, released on a falling edge
    initial
    begin
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // ------------------------------------------------------------------
    // Pending character transfers and expected answers
    // ------------------------------------------------------------------
    typedef struct {
        char_t       ch;
        int unsigned gap;    // idle cycles after this transfer
        bit          drain;  // hold off until all answers are back
    } pend_item_t;

    pend_item_t  char_queue[$];
    result_t     pending_answers[$];
    byte unsigned draft[$];  // expression under construction

    byte unsigned op_list[5] = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_CARET};

    int unsigned fail_cnt = 0;
    int unsigned expr_cnt = 0;
    int unsigned char_cnt = 0;
    int unsigned status_hist[4] = '{0, 0, 0, 0};

    // ------------------------------------------------------------------
    // Evaluator mirror: value stack, digit accumulator, sticky status
    // ------------------------------------------------------------------
    logic [DATA_W-1:0] stack_mem [STACK_DEPTH];
    int unsigned       depth_cnt = 0;
    logic [DATA_W-1:0] num_acc   = '0;
    logic              num_open  = 1'b0;
    logic [1:0]        sticky    = ST_OK;

    // first error of an expression is the one reported
    task note_error(input logic [1:0] code);
        if (sticky == ST_OK)
            sticky = code;
    endtask

    // push onto a full stack drops the value
    task push_val(input logic [DATA_W-1:0] v);
        if (depth_cnt >= STACK_DEPTH)
            note_error(ST_OVER);
        else
        begin
            stack_mem[depth_cnt] = v;
            depth_cnt++;
        end
    endtask

    task flush_num();
        if (num_open)
        begin
            push_val(num_acc);
            num_acc  = '0;
            num_open = 1'b0;
        end
    endtask

    // one accepted character; on the last one, queue the expected answer
    task eval_char(input char_t c);
        logic [DATA_W-1:0] lhs;
        logic [DATA_W-1:0] rhs;
        logic [DATA_W-1:0] res;
        bit                is_op;
        result_t           ans;
        if (c.char_code >= CH_ZERO && c.char_code <= CH_NINE)
        begin
            num_acc  = num_acc * 32'd10 + {24'd0, c.char_code - CH_ZERO};
            num_open = 1'b1;
        end
        else
        begin
            flush_num();
            case (c.char_code)
                CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_CARET: is_op = 1'b1;
                default:                                        is_op = 1'b0;
            endcase
            if (is_op)
            begin
                // short of operands: operator is dropped, stack untouched
                if (depth_cnt < 2)
                    note_error(ST_UNDER);
                else
                begin
                    rhs = stack_mem[depth_cnt-1];
                    lhs = stack_mem[depth_cnt-2];
                    depth_cnt -= 2;
                    res = '0;
                    case (c.char_code)
                        CH_PLUS:  res = lhs + rhs;
                        CH_MINUS: res = lhs - rhs;
                        CH_STAR:  res = lhs * rhs;
                        CH_SLASH:
                        begin
                            if (rhs == '0)
                            begin
                                note_error(ST_DIVZ);
                                res = '0;
                            end
                            else if (lhs == 32'h8000_0000 && rhs == '1)
                                res = lhs;  // most negative / -1 wraps
                            else
                                res = $signed(lhs) / $signed(rhs);
                        end
                        default:  res = '0;  // caret
                    endcase
                    push_val(res);
                end
            end
        end

        if (c.end_mark)
        begin
            flush_num();
            ans.value = '0;
            if (depth_cnt == 0)
                note_error(ST_UNDER);
            else
                ans.value = stack_mem[depth_cnt-1];
            ans.status = sticky;
            pending_answers.push_back(ans);
            status_hist[sticky]++;
            depth_cnt = 0;
            num_acc   = '0;
            num_open  = 1'b0;
            sticky    = ST_OK;
        end
    endtask

    // ------------------------------------------------------------------
    // Character driver: changes on the falling edge, fed by char_queue
    // ------------------------------------------------------------------
    logic        char_taken = 1'b0;
    int unsigned tx_gap     = 0;
    pend_item_t  tx_item;

    always @(posedge clk)
    begin
        char_taken <= rst_n && char_valid && !char_stall;
        if (rst_n && char_valid && !char_stall)
            eval_char(char_data);
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            char_valid <= 1'b0;
        else if (char_valid && !char_taken)
            ;  // stalled: payload holds
        else if (tx_gap > 0)
        begin
            char_valid <= 1'b0;
            tx_gap--;
        end
        else if (char_queue.size() != 0 && char_queue[0].drain)
        begin
            char_valid <= 1'b0;
            if (pending_answers.size() == 0)
                void'(char_queue.pop_front());
        end
        else if (char_queue.size() != 0)
        begin
            tx_item    = char_queue.pop_front();
            char_data  <= tx_item.ch;
            char_valid <= 1'b1;
            tx_gap     = tx_item.gap;
        end
        else
            char_valid <= 1'b0;
    end

    // ------------------------------------------------------------------
    // Result monitor: random stall after each transfer, with quiet spells
    // ------------------------------------------------------------------
    logic        result_taken = 1'b0;
    int unsigned rx_stall     = 3;
    bit          rx_quiet     = 1'b0;
    result_t     answer_head;

    always @(negedge clk)
    begin
        if (!rst_n)
            result_stall <= 1'b0;
        else
        begin
            if (result_taken)
            begin
                if ($urandom_range(0, 7) == 0)
                    rx_quiet = !rx_quiet;
                rx_stall = rx_quiet ? 0 : $urandom_range(0, 7);
            end
            if (rx_stall > 0)
            begin
                result_stall <= 1'b1;
                rx_stall--;
            end
            else
                result_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        result_taken <= rst_n && result_valid && !result_stall;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_answers.size() == 0)
            begin
                $error("unexpected result: value %0d status %0d",
                       result_data.value, result_data.status);
                fail_cnt++;
            end
            else
            begin
                answer_head = pending_answers.pop_front();
                if (result_data.value !== answer_head.value)
                begin
                    $error("value: expected %0d, got %0d",
                           answer_head.value, result_data.value);
                    fail_cnt++;
                end
                if (result_data.status !== answer_head.status)
                begin
                    $error("status: expected %0d, got %0d",
                           answer_head.status, result_data.status);
                    fail_cnt++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Expression construction
    // ------------------------------------------------------------------
    function automatic bit digit_code(input byte unsigned b);
        return b >= CH_ZERO && b <= CH_NINE;
    endfunction

    // draft becomes one expression; end_mark on its last character
    task queue_draft(input bit burst);
        pend_item_t it;
        for (int i = 0; i < draft.size(); i++)
        begin
            it.ch.char_code = draft[i];
            it.ch.end_mark  = (i == draft.size() - 1);
            it.gap          = burst ? 0 : $urandom_range(0, 7);
            it.drain        = 1'b0;
            char_queue.push_back(it);
        end
        char_cnt += draft.size();
        expr_cnt++;
        draft.delete();
    endtask

    task queue_drain();
        pend_item_t it;
        it.ch    = '0;
        it.gap   = 0;
        it.drain = 1'b1;
        char_queue.push_back(it);
    endtask

    task add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            draft.push_back(s[i]);
    endtask

    // mostly blanks, sometimes any byte that is neither digit nor operator
    task add_sep();
        byte unsigned b;
        if ($urandom_range(0, 3) != 0)
            draft.push_back(8'h20);
        else
        begin
            do
                b = byte'($urandom_range(0, 255));
            while (digit_code(b) || b == CH_PLUS || b == CH_MINUS || b == CH_STAR ||
                   b == CH_SLASH || b == CH_CARET);
            draft.push_back(b);
        end
    endtask

    task put_number(input int unsigned n);
        if (draft.size() != 0 && digit_code(draft[$]))
            add_sep();
        add_text($sformatf("%0d", n));
    endtask

    task put_random_number();
        int unsigned len;
        case ($urandom_range(0, 9))
            0:          put_number(0);
            6, 7:       put_number($urandom_range(0, 100000));
            8:          put_number($urandom);
            9:
            begin
                // longer than 32 bits can hold: accumulator wraps
                if (draft.size() != 0 && digit_code(draft[$]))
                    add_sep();
                len = $urandom_range(11, 13);
                for (int i = 0; i < len; i++)
                    draft.push_back(byte'(CH_ZERO + $urandom_range(0, 9)));
            end
            default:    put_number($urandom_range(0, 99));
        endcase
    endtask

    // random tree of n operands, fully reduced to one value
    task build_wellformed(input int unsigned n);
        int unsigned depth;
        int unsigned pushed;
        depth  = 0;
        pushed = 0;
        while (pushed < n || depth > 1)
        begin
            if (pushed < n && (depth < 2 || $urandom_range(0, 1)))
            begin
                put_random_number();
                depth++;
                pushed++;
            end
            else
            begin
                draft.push_back(op_list[$urandom_range(0, 4)]);
                depth--;
                if ($urandom_range(0, 3) == 0)
                    add_sep();
            end
        end
        if ($urandom_range(0, 2) == 0)
            add_sep();
    endtask

    // long run of pushes; past the stack depth the extras are dropped
    task build_deep(input int unsigned n);
        int unsigned idx;
        for (int i = 0; i < n; i++)
            put_number($urandom_range(0, 9));
        for (int i = 1; i < n; i++)
        begin
            idx = $urandom_range(0, 3);
            draft.push_back(op_list[(idx == 3) ? 4 : idx]);
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    int unsigned char_goal;
    int unsigned pick;
    bit          mid_drained;
    bit          first_rand;

    initial
    begin
        // directed: truncating divide of a negative, divide by zero, mul and
        // add, caret, operator on an empty stack, digit as last character,
        // all-ones literal
        add_text("0 7-2/");     queue_draft(1'b0);
        add_text("5 0/");       queue_draft(1'b1);
        add_text("6 7*3+");     queue_draft(1'b0);
        add_text("2 3^");       queue_draft(1'b0);
        add_text("+");          queue_draft(1'b0);
        add_text("9");          queue_draft(1'b1);
        add_text("4294967295"); queue_draft(1'b0);
        queue_drain();

        char_goal   = char_cnt + 1800;
        mid_drained = 1'b0;
        first_rand  = 1'b1;
        while (char_cnt < char_goal)
        begin
            pick = $urandom_range(0, 99);
            if (first_rand)
                build_deep(66);  // guaranteed overflow
            else if (pick < 65)
                build_wellformed($urandom_range(1, 8));
            else if (pick < 75)
            begin
                // missing operand: operator up front or one too many at the end
                build_wellformed($urandom_range(1, 5));
                if ($urandom_range(0, 1))
                    draft.push_front(op_list[$urandom_range(0, 4)]);
                else
                    draft.push_back(op_list[$urandom_range(0, 4)]);
            end
            else if (pick < 80)
            begin
                if ($urandom_range(0, 1))
                    add_text("2147483648 0 1-/");  // most negative by -1
                else
                    add_text("2147483647 1+ 65536 65536*-");
            end
            else if (pick < 83)
                build_deep($urandom_range(60, 68));
            else
            begin
                // raw bytes of any value
                for (int i = $urandom_range(1, 12); i > 0; i--)
                    draft.push_back(byte'($urandom_range(0, 255)));
            end
            first_rand = 1'b0;
            queue_draft($urandom_range(0, 3) == 0);
            if (!mid_drained && char_cnt > char_goal / 2)
            begin
                queue_drain();
                mid_drained = 1'b1;
            end
        end

        while (char_queue.size() != 0 || char_valid)
            @(posedge clk);
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (64) @(posedge clk);

        $display("Ran %0d expressions, %0d characters; status ok %0d, underflow %0d,",
                 expr_cnt, char_cnt, status_hist[ST_OK], status_hist[ST_UNDER]);
        $display("overflow %0d, divide by zero %0d; %0d field errors",
                 status_hist[ST_OVER], status_hist[ST_DIVZ], fail_cnt);
        if (fail_cnt == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // hard stop well beyond the slowest legal run
    initial
    begin
        #1500000;
        $error("run did not finish in time");
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ files.f @@
rtl/pse_pkg.sv
rtl/pse_stack.sv
rtl/pse_alu.sv
rtl/postfix_stack_evaluator.sv
sim/tb_top.sv
